[src/gbia_pkg.sv]
// shared constants and types for the grouped bitmap id allocator
`timescale 1ns / 1ps
`default_nettype none
package gbia_pkg;
   localparam int GROUPS        = 16;
   localparam int IDS_PER_GROUP = 64;
   localparam int GW            = $clog2(GROUPS);
   localparam int BW            = $clog2(IDS_PER_GROUP);
   localparam int GCW           = GW + 1;

   localparam logic       OP_ALLOC = 1'b0;
   localparam logic       OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NONE  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_REF   = 2'd3;

   localparam logic [1:0] REG_GROUPS = 2'd0;
   localparam logic [1:0] REG_PER    = 2'd1;
   localparam logic [1:0] REG_FIRST  = 2'd2;
   localparam logic [1:0] REG_TOTAL  = 2'd3;

   localparam logic [6:0]  CNT7_MAX  = 7'd127;
   localparam logic [10:0] CNT11_MAX = 11'd2047;
   localparam int          TOT_RAW   = GROUPS * IDS_PER_GROUP;
   localparam logic [10:0] TOT_RESET = (TOT_RAW > 2047) ? 11'd2047 : 11'(TOT_RAW);

   // datapath commands issued by the controller
   typedef struct packed {
      logic load;       // capture request and clamped start group
      logic scan_grp;   // evaluate current group of the scan
      logic scan_next;  // advance scan group
      logic div_start;  // initialize division of id-1
      logic div_step;   // one restoring division step
      logic idmul;      // latch lowest free bit for the candidate id
      logic commit;     // update state and build result
      logic fail;       // build failure result with given status
      logic [1:0] fail_status;
   } cmd_type;

   // datapath status to the controller
   typedef struct packed {
      logic is_free;
      logic refd;
      logic range_bad;  // free id range check failed
      logic no_groups;  // zero effective groups or zero per group
      logic grp_found;  // current scan group has a free bit
      logic scan_last;  // current scan group is the last one to scan
      logic div_done;
      logic grp_bad;    // free group not below groups in use
      logic id_bad;     // allocated candidate out of range
   } sts_type;
endpackage
`default_nettype wire

[src/grouped_bitmap_id_allocator.sv]
// top level of the grouped bitmap id allocator
// One request at a time. Allocate scans the bitmap state one group per cycle,
// over up to 16 groups; an allocate that finds no free bit fails once the
// groups in use are scanned. Free uses the 11-step bit-serial divider that
// splits the id into group and bit. Failed checks before the scan or divide
// end the request without either. The result sits in an output register; the
// next request is taken no earlier than the cycle in which that result is
// transferred, and a stalled result holds off the next request.
`timescale 1ns / 1ps
`default_nettype none
module grouped_bitmap_id_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [3:0]  req_start_group,
   input  wire logic        req_is_directory,
   input  wire logic [10:0] req_free_id,
   input  wire logic        req_still_referenced,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [10:0]      rsp_given_id,
   output logic [3:0]       rsp_group_used,
   output logic [10:0]      rsp_free_total
);
   import gbia_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   gbia_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   // state and arithmetic
   gbia_dp u_dp (
      .clock, .reset, .cmd, .sts, .csr_write, .csr_index, .csr_data,
      .req_opcode, .req_start_group, .req_is_directory, .req_free_id,
      .req_still_referenced,
      .rsp_fire(rsp_valid && !rsp_stall),
      .rsp_status, .rsp_given_id, .rsp_group_used, .rsp_free_total
   );
endmodule
`default_nettype wire

[src/gbia_ctrl.sv]
// controller state machine of the grouped bitmap id allocator
`timescale 1ns / 1ps
`default_nettype none
module gbia_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire gbia_pkg::sts_type sts,
   output gbia_pkg::cmd_type     cmd
);
   import gbia_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_SCAN, S_DIV, S_IDMUL, S_DECIDE, S_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_hold;

   // a result still waiting in the output register blocks the next request
   assign rsp_hold  = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_hold;
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE:  cmd.load = req_valid && !rsp_hold;
         S_CHECK: begin
            if (sts.is_free) begin
               if (sts.refd) begin
                  cmd.fail = 1'b1; cmd.fail_status = ST_REF;
               end else if (sts.range_bad || sts.no_groups) begin
                  cmd.fail = 1'b1; cmd.fail_status = ST_RANGE;
               end else begin
                  cmd.div_start = 1'b1;
               end
            end else if (sts.no_groups) begin
               cmd.fail = 1'b1; cmd.fail_status = ST_NONE;
            end
         end
         S_SCAN: begin
            cmd.scan_grp = 1'b1;
            if (sts.grp_found) cmd.idmul = 1'b1;
            else if (sts.scan_last) begin
               cmd.fail = 1'b1; cmd.fail_status = ST_NONE;
            end else cmd.scan_next = 1'b1;
         end
         S_DIV: begin
            if (sts.div_done) begin
               if (sts.grp_bad) begin
                  cmd.fail = 1'b1; cmd.fail_status = ST_RANGE;
               end else cmd.commit = 1'b1;
            end else cmd.div_step = 1'b1;
         end
         S_IDMUL: ;
         S_DECIDE: begin
            if (sts.id_bad) begin
               cmd.fail = 1'b1; cmd.fail_status = ST_NONE;
            end else cmd.commit = 1'b1;
         end
         S_OUT: ;
         default: ;
      endcase
   end

   // state and registered response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE:  if (req_valid && !rsp_hold) state_ff <= S_CHECK;
            S_CHECK: begin
               if (cmd.fail) state_ff <= S_OUT;
               else if (cmd.div_start) state_ff <= S_DIV;
               else state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (cmd.idmul) state_ff <= S_IDMUL;
               else if (cmd.fail) state_ff <= S_OUT;
            end
            S_DIV:    if (sts.div_done) state_ff <= S_OUT;
            S_IDMUL:  state_ff <= S_DECIDE;
            S_DECIDE: state_ff <= S_OUT;
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // no new request is taken while busy
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request accepted while busy");
   // response only raised on leaving the output state
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside output state");
   // a pending response is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && rsp_stall) |=> state_ff == S_OUT)
      else $error("response overwritten");
endmodule
`default_nettype wire

[src/gbia_dp.sv]
// datapath of the grouped bitmap id allocator: state, scan, divider and result
`timescale 1ns / 1ps
`default_nettype none
module gbia_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gbia_pkg::cmd_type cmd,
   output gbia_pkg::sts_type      sts,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [10:0]       csr_data,
   input  wire logic              req_opcode,
   input  wire logic [3:0]        req_start_group,
   input  wire logic              req_is_directory,
   input  wire logic [10:0]       req_free_id,
   input  wire logic              req_still_referenced,
   input  wire logic              rsp_fire,
   output logic [1:0]             rsp_status,
   output logic [10:0]            rsp_given_id,
   output logic [3:0]             rsp_group_used,
   output logic [10:0]            rsp_free_total
);
   import gbia_pkg::*;

   // configuration registers
   logic [4:0]  groups_ff;
   logic [6:0]  per_ff;
   logic [10:0] first_ff, total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         groups_ff <= 5'd16;
         per_ff    <= 7'd64;
         first_ff  <= 11'd11;
         total_ff  <= 11'd1024;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_GROUPS: groups_ff <= csr_data[4:0];
            REG_PER:    per_ff    <= csr_data[6:0];
            REG_FIRST:  first_ff  <= csr_data;
            REG_TOTAL:  total_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // effective limits
   logic [GCW-1:0] ng;
   logic [BW:0]    per;
   assign ng  = (32'(groups_ff) > GROUPS) ? GCW'(GROUPS) : GCW'(groups_ff);
   assign per = (32'(per_ff) > IDS_PER_GROUP) ? (BW+1)'(IDS_PER_GROUP) : (BW+1)'(per_ff);

   // captured request
   logic           op_ff, dir_ff, refd_ff;
   logic [10:0]    fid_ff;
   logic [GCW-1:0] grp_ff;
   logic [GCW-1:0] cnt_ff;

   // group state
   logic [IDS_PER_GROUP-1:0] bmap_ff [GROUPS];
   logic [6:0]               gfree_ff [GROUPS];
   logic [6:0]               gdir_ff  [GROUPS];
   logic [10:0]              tfree_ff;

   // division registers: quotient/remainder of id-1 by per
   logic [10:0] dquo_ff;
   logic [BW+1:0] drem_ff;
   logic [3:0]  dstep_ff;

   // found bit and candidate id
   logic [BW-1:0] bit_ff;
   logic [10:0]   id_ff;
   logic [GW-1:0] gsel;

   // current group (wrap handled at load/advance)
   assign gsel = grp_ff[GW-1:0];

   // lowest clear bit below per in selected group
   logic [IDS_PER_GROUP-1:0] avail;
   logic [BW-1:0]            low_bit;
   logic                     any_bit;
   always_comb begin
      for (int b = 0; b < IDS_PER_GROUP; b++)
         avail[b] = !bmap_ff[gsel][b] && (b < 32'(per));
      low_bit = '0;
      any_bit = 1'b0;
      for (int b = IDS_PER_GROUP-1; b >= 0; b--)
         if (avail[b]) begin
            low_bit = BW'(b);
            any_bit = 1'b1;
         end
   end

   // divider trial subtract
   logic [BW+1:0] rem_sh;
   logic          rem_ge;
   assign rem_sh = {drem_ff[BW:0], dquo_ff[10]};
   assign rem_ge = rem_sh >= (BW+2)'(per);

   // status to controller
   always_comb begin
      sts.is_free   = op_ff;
      sts.refd      = refd_ff;
      sts.range_bad = (fid_ff == 11'd0) || (fid_ff < first_ff) || (fid_ff > total_ff);
      sts.no_groups = (ng == '0) || (per == '0);
      sts.grp_found = (gfree_ff[gsel] != 7'd0) && any_bit;
      sts.scan_last = (cnt_ff + GCW'(1)) >= ng;
      sts.div_done  = (dstep_ff == 4'd11);
      sts.grp_bad   = (dquo_ff >= 11'(ng));
      sts.id_bad    = (id_ff < first_ff) || (id_ff > total_ff);
   end

   // output registers
   logic [1:0]  st_ff;
   logic [10:0] gid_ff, ftot_ff;
   logic [3:0]  gu_ff;
   assign rsp_status     = st_ff;
   assign rsp_given_id   = gid_ff;
   assign rsp_group_used = gu_ff;
   assign rsp_free_total = ftot_ff;

   // commit targets
   logic [GW-1:0] cgrp;
   logic [BW-1:0] cbit;
   assign cgrp = op_ff ? dquo_ff[GW-1:0] : gsel;
   assign cbit = op_ff ? drem_ff[BW-1:0] : bit_ff;

   // request capture, scan, divide and id build
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         dir_ff  <= req_is_directory;
         refd_ff <= req_still_referenced;
         fid_ff  <= req_free_id;
         grp_ff  <= (GCW'(req_start_group) >= ng) ? '0 : GCW'(req_start_group);
         cnt_ff  <= '0;
      end
      if (cmd.scan_next) begin
         grp_ff <= (grp_ff + GCW'(1) >= ng) ? '0 : grp_ff + GCW'(1);
         cnt_ff <= cnt_ff + GCW'(1);
      end
      if (cmd.idmul) bit_ff <= low_bit;
      if (cmd.div_start) begin
         dquo_ff  <= fid_ff - 11'd1;
         drem_ff  <= '0;
         dstep_ff <= '0;
      end
      if (cmd.div_step) begin
         drem_ff  <= rem_ge ? rem_sh - (BW+2)'(per) : rem_sh;
         dquo_ff  <= {dquo_ff[9:0], rem_ge};
         dstep_ff <= dstep_ff + 4'd1;
      end
      id_ff <= 11'(grp_ff) * 11'(per) + 11'(bit_ff) + 11'd1;
   end

   // state updates and results
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < GROUPS; g++) begin
            bmap_ff[g]  <= '0;
            gfree_ff[g] <= 7'(IDS_PER_GROUP);
            gdir_ff[g]  <= '0;
         end
         tfree_ff <= TOT_RESET;
         ftot_ff  <= TOT_RESET;
         st_ff    <= ST_OK;
         gid_ff   <= '0;
         gu_ff    <= '0;
      end else begin
         if (cmd.fail) begin
            st_ff   <= cmd.fail_status;
            gid_ff  <= '0;
            gu_ff   <= '0;
            ftot_ff <= tfree_ff;
         end else if (cmd.commit) begin
            st_ff <= ST_OK;
            gu_ff <= 4'(cgrp);
            if (!op_ff) begin
               bmap_ff[cgrp][cbit] <= 1'b1;
               gfree_ff[cgrp] <= (gfree_ff[cgrp] == 0) ? 7'd0 : gfree_ff[cgrp] - 7'd1;
               if (dir_ff)
                  gdir_ff[cgrp] <= (gdir_ff[cgrp] == CNT7_MAX) ? CNT7_MAX
                                   : gdir_ff[cgrp] + 7'd1;
               tfree_ff <= (tfree_ff == 0) ? 11'd0 : tfree_ff - 11'd1;
               ftot_ff  <= (tfree_ff == 0) ? 11'd0 : tfree_ff - 11'd1;
               gid_ff   <= id_ff;
            end else begin
               bmap_ff[cgrp][cbit] <= 1'b0;
               gfree_ff[cgrp] <= (gfree_ff[cgrp] == CNT7_MAX) ? CNT7_MAX
                                 : gfree_ff[cgrp] + 7'd1;
               if (dir_ff)
                  gdir_ff[cgrp] <= (gdir_ff[cgrp] == 0) ? 7'd0 : gdir_ff[cgrp] - 7'd1;
               tfree_ff <= (tfree_ff == CNT11_MAX) ? CNT11_MAX : tfree_ff + 11'd1;
               ftot_ff  <= (tfree_ff == CNT11_MAX) ? CNT11_MAX : tfree_ff + 11'd1;
               gid_ff   <= '0;
            end
         end
      end
   end

   // commit and fail are never issued together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && cmd.fail))
      else $error("commit and fail together");
   // scan group stays below the groups in use
   a_grp: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_grp |-> grp_ff < ng)
      else $error("scan group out of range");
   // a fail result never carries an id
   a_fail_id: assert property (@(posedge clock) disable iff (reset)
      cmd.fail |=> gid_ff == 11'd0)
      else $error("id given on failure");
   // the result is never taken in a cycle that commits
   a_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> !cmd.commit)
      else $error("commit while result taken");
endmodule
`default_nettype wire
